[sv/pttf_pkg.sv]
// ----------------------------------------------------------------------------
// pttf_pkg
// Shared types and constants for the programmable transition table FSM.
// ----------------------------------------------------------------------------
`default_nettype none

package pttf_pkg;

    // Table geometry.
    localparam int NUM_STATES = 16;
    localparam int RULE_DEPTH = 16;
    localparam int EVENT_BITS = 8;

    // Fixed field widths of the request and response.
    localparam int STATE_W  = 4;
    localparam int EVENT_W  = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = $clog2(RULE_DEPTH + 1);

    typedef logic [STATE_W-1:0]    state_code_t;
    typedef logic [EVENT_BITS-1:0] event_code_t;
    typedef logic [COUNT_W-1:0]    rule_count_t;

    // Request operations.
    typedef enum logic [1:0] {
        OP_DEFINE = 2'd0,
        OP_ADD    = 2'd1,
        OP_FORCE  = 2'd2,
        OP_EVENT  = 2'd3
    } opcode_t;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_UNDEF   = 3'd1,
        ST_DUP     = 3'd2,
        ST_FULL    = 3'd3,
        ST_NOMATCH = 3'd4
    } status_t;

    // Search result handed from one rule cell to the next, in insertion order.
    typedef struct packed {
        logic        dup;
        logic        hit;
        state_code_t to_state;
        logic        notify;
    } chain_t;

endpackage

`default_nettype wire

[sv/pttf_cell.sv]
// ----------------------------------------------------------------------------
// pttf_cell
// One rule slot: holds a stored rule, compares it against the broadcast key
// and merges its result into the priority chain from the earlier slots.
// ----------------------------------------------------------------------------
`default_nettype none

module pttf_cell (
    input  wire logic                  clk,
    input  wire logic                  occupied,
    input  wire logic                  wr_en,
    input  wire pttf_pkg::state_code_t wr_from,
    input  wire pttf_pkg::state_code_t wr_to,
    input  wire pttf_pkg::event_code_t wr_event,
    input  wire logic                  wr_notify,
    input  wire pttf_pkg::state_code_t key_from,
    input  wire pttf_pkg::state_code_t key_to,
    input  wire pttf_pkg::event_code_t key_event,
    input  wire pttf_pkg::chain_t      chain_in,
    output pttf_pkg::chain_t           chain_out
);
    import pttf_pkg::*;

    state_code_t from_reg;
    state_code_t to_reg;
    event_code_t event_reg;
    logic        notify_reg;

    logic rule_match;
    logic dup_match;

    // Rule storage; only written when this slot is the next free one.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            from_reg   <= wr_from;
            to_reg     <= wr_to;
            event_reg  <= wr_event;
            notify_reg <= wr_notify;
        end
    end

    // Compare this slot against the key.
    assign rule_match = occupied && (from_reg == key_from) && (event_reg == key_event);
    assign dup_match  = rule_match && (to_reg == key_to);

    // An earlier hit keeps priority; otherwise this slot supplies the target.
    always_comb
    begin
        chain_out.dup = chain_in.dup | dup_match;
        chain_out.hit = chain_in.hit | rule_match;
        if (chain_in.hit)
        begin
            chain_out.to_state = chain_in.to_state;
            chain_out.notify   = chain_in.notify;
        end
        else
        begin
            chain_out.to_state = to_reg;
            chain_out.notify   = notify_reg;
        end
    end

endmodule

`default_nettype wire

[sv/programmable_transition_table_fsm.sv]
// ----------------------------------------------------------------------------
// programmable_transition_table_fsm
// Table-driven state machine with run-time programmable states and rules.
// ----------------------------------------------------------------------------
// The block takes one request per clock unless a held response stalls it, and
// returns one response per request through an output register; req_ready stays
// high while that register is empty or being drained. The rules sit in a row
// of RULE_DEPTH slot cells; a lookup compares every slot at once and the first
// match in insertion order is carried down the row of cells, so the length of
// that row sets the critical path. Rules are appended at the fill count and
// never removed; state codes are marked defined by the define operation.
`default_nettype none

module programmable_transition_table_fsm (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_ready,
    input  wire logic [1:0]             opcode,
    input  wire logic [3:0]             state_a,
    input  wire logic [3:0]             state_b,
    input  wire logic [7:0]             event_value,
    input  wire logic                   notify_enable,
    output logic                        rsp_valid,
    input  wire logic                   rsp_ready,
    output logic [2:0]                  status,
    output logic [3:0]                  current_state,
    output logic                        matched,
    output logic [3:0]                  previous_state,
    output logic                        notify_fired
);
    import pttf_pkg::*;

    // Architectural state.
    state_code_t             present_reg;
    state_code_t             present_next;
    logic [NUM_STATES-1:0]   defined_reg;
    logic [NUM_STATES-1:0]   defined_next;
    rule_count_t             count_reg;
    rule_count_t             count_next;

    // Response register.
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    status_t     status_reg;
    status_t     status_next;
    state_code_t cur_reg;
    state_code_t prev_reg;
    logic        matched_reg;
    logic        matched_next;
    logic        fired_reg;
    logic        fired_next;

    logic        accept;
    opcode_t     op;
    event_code_t ev;
    state_code_t key_from;
    logic        a_defined;
    logic        b_defined;
    logic        add_ok;
    chain_t      chain_link [RULE_DEPTH+1];

    assign op = opcode_t'(opcode);
    assign ev = event_value[EVENT_BITS-1:0];

    // Handshake: a new request is taken whenever the response slot frees up.
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    // A code is defined only if it lies in range and has been marked.
    assign a_defined = (int'(state_a) < NUM_STATES) && defined_reg[state_a];
    assign b_defined = (int'(state_b) < NUM_STATES) && defined_reg[state_b];

    // Events search from the present state, rule adds from the new source.
    assign key_from = (op == OP_EVENT) ? present_reg : state_a;

    // Head of the rule chain: nothing found yet.
    assign chain_link[0] = '{dup: 1'b0, hit: 1'b0, to_state: '0, notify: 1'b0};

    // Rule slot cells, first stored rule at the head of the row.
    for (genvar i = 0; i < RULE_DEPTH; i++)
    begin : g_cell
        logic slot_used;
        logic slot_wr;

        assign slot_used = count_reg > COUNT_W'(i);
        assign slot_wr   = accept && add_ok && (count_reg == COUNT_W'(i));

        pttf_cell u_cell (
            .clk       (clk),
            .occupied  (slot_used),
            .wr_en     (slot_wr),
            .wr_from   (state_a),
            .wr_to     (state_b),
            .wr_event  (ev),
            .wr_notify (notify_enable),
            .key_from  (key_from),
            .key_to    (state_b),
            .key_event (ev),
            .chain_in  (chain_link[i]),
            .chain_out (chain_link[i+1])
        );
    end

    // A rule is stored when both ends are defined, it is new and there is room.
    assign add_ok = (op == OP_ADD) && a_defined && b_defined &&
                    !chain_link[RULE_DEPTH].dup && (int'(count_reg) < RULE_DEPTH);

    // Operation decode: next machine state and the response fields.
    always_comb
    begin
        present_next   = present_reg;
        defined_next   = defined_reg;
        count_next     = count_reg;
        status_next    = ST_OK;
        matched_next   = 1'b0;
        fired_next     = 1'b0;
        case (op)
            OP_DEFINE:
            begin
                if (int'(state_a) < NUM_STATES)
                begin
                    defined_next[state_a] = 1'b1;
                    present_next          = state_a;
                end
                else
                begin
                    status_next = ST_UNDEF;
                end
            end
            OP_ADD:
            begin
                if (!a_defined || !b_defined)
                begin
                    status_next = ST_UNDEF;
                end
                else if (chain_link[RULE_DEPTH].dup)
                begin
                    status_next = ST_DUP;
                end
                else if (int'(count_reg) >= RULE_DEPTH)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            OP_FORCE:
            begin
                if (a_defined)
                begin
                    present_next = state_a;
                end
                else
                begin
                    status_next = ST_UNDEF;
                end
            end
            OP_EVENT:
            begin
                if (chain_link[RULE_DEPTH].hit)
                begin
                    present_next = chain_link[RULE_DEPTH].to_state;
                    matched_next = 1'b1;
                    fired_next   = chain_link[RULE_DEPTH].notify;
                end
                else
                begin
                    status_next = ST_NOMATCH;
                end
            end
            default:
            begin
                status_next = ST_NOMATCH;
            end
        endcase
    end

    // Response valid tracks accepts and drains.
    always_comb
    begin
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg   <= '0;
            defined_reg   <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                present_reg <= present_next;
                defined_reg <= defined_next;
                count_reg   <= count_next;
            end
        end
    end

    // Response payload, loaded with each accepted request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            cur_reg     <= present_next;
            prev_reg    <= present_reg;
            matched_reg <= matched_next;
            fired_reg   <= fired_next;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign current_state  = cur_reg;
    assign matched        = matched_reg;
    assign previous_state = prev_reg;
    assign notify_fired   = fired_reg;

endmodule

`default_nettype wire
